[hw/rtl/hcs_pkg.sv]
// Shared types and helpers for the histogram contrast stretch core.
// No dependencies; used by hcs_stats, hcs_div and the top level.
package hcs_pkg;

    localparam int unsigned NumChan = 3;
    localparam int unsigned PixW    = 8;
    localparam int unsigned NumW    = 2 * PixW;

    localparam logic [PixW-1:0] PixMax = '1;
    localparam logic [PixW-1:0] PixMin = '0;

    // Control for the statistics registers.
    typedef struct packed {
        logic fold;
        logic clear;
    } stats_ctl_t;

    // Status reported by the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Luma (r*11 + g*16 + b*5) / 32, rounded down; the sum fits in 13 bits.
    function automatic logic [PixW-1:0] luma_of(input logic [PixW-1:0] r,
                                                 input logic [PixW-1:0] g,
                                                 input logic [PixW-1:0] b);
        logic [PixW+4:0] sum;
        sum = ({5'd0, r} << 3) + ({5'd0, r} << 1) + {5'd0, r}
            + ({5'd0, g} << 4)
            + ({5'd0, b} << 2) + {5'd0, b};
        return sum[PixW+4:5];
    endfunction

endpackage

[hw/rtl/histogram_contrast_stretch_core.sv]
// Histogram contrast stretch core. Gather requests (mode 0) fold a pixel, or
// its luma in gray mode, into per-channel min/max. Apply requests (mode 1)
// produce one stretched pixel; each stretched channel goes through one shared
// 8-step restoring divider, with a setup step that starts the divider, eight
// divide steps and a done step. An apply passes through accept, the channel
// steps and finish, for three channels in color mode and one in gray mode,
// and is shorter when a channel is flat, below its minimum or saturates.
// The result sits in an output register, so the next request is taken while
// it waits; an apply that finishes while that register is still full waits in
// its last state until the result is taken.
module histogram_contrast_stretch_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic       s_first_of_frame,
    input  logic [7:0] s_in_red,
    input  logic [7:0] s_in_green,
    input  logic [7:0] s_in_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_red,
    output logic [7:0] m_out_green,
    output logic [7:0] m_out_blue
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_SETUP,
        ST_DIV,
        ST_FINISH
    } state_t;

    localparam int unsigned PW = hcs_pkg::PixW;
    localparam int unsigned NC = hcs_pkg::NumChan;

    state_t                   state_reg, state_next;
    logic [1:0]               chan_reg, chan_next;
    logic                     gray_mode_reg, gray_mode_next;
    logic                     first_reg, first_next;
    logic [NC-1:0][PW-1:0]    px_reg, px_next;
    logic [PW-1:0]            luma_reg, luma_next;
    logic [NC-1:0][PW-1:0]    res_reg, res_next;
    logic                     m_valid_reg, m_valid_next;
    logic [NC-1:0][PW-1:0]    m_pix_reg, m_pix_next;

    hcs_pkg::stats_ctl_t      stats_ctl;
    logic [NC-1:0][PW-1:0]    stats_val;
    logic [NC-1:0][PW-1:0]    min_q, max_q;

    logic                     div_start;
    hcs_pkg::div_status_t     div_status;
    logic [PW-1:0]            div_quot;

    logic                     accept;
    logic                     advance;
    logic [PW-1:0]            cur_v, cur_lo, cur_hi, v_off, den;
    logic [hcs_pkg::NumW-1:0] num;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    assign stats_ctl.fold  = (state_reg == ST_GATHER);
    assign stats_ctl.clear = first_reg;
    assign stats_val = gray_mode_reg ? {NC{luma_reg}} : px_reg;

    hcs_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (stats_ctl),
        .val     (stats_val),
        .min_q   (min_q),
        .max_q   (max_q)
    );

    // Gray mode always works on entry 0, since chan_reg stays at zero there.
    assign cur_v  = gray_mode_reg ? luma_reg : px_reg[chan_reg];
    assign cur_lo = min_q[chan_reg];
    assign cur_hi = max_q[chan_reg];
    assign v_off  = cur_v - cur_lo;
    assign den    = cur_hi - cur_lo;
    assign num    = {v_off, {PW{1'b0}}} - {{PW{1'b0}}, v_off};

    hcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num),
        .divisor  (den),
        .status   (div_status),
        .quotient (div_quot)
    );

    always_comb begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        gray_mode_next = cfg_wr_en ? cfg_wr_data : gray_mode_reg;
        first_next     = first_reg;
        px_next        = px_reg;
        luma_next      = luma_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_pix_next     = m_pix_reg;
        div_start      = 1'b0;
        advance        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    first_next = s_first_of_frame;
                    px_next    = {s_in_blue, s_in_green, s_in_red};
                    luma_next  = hcs_pkg::luma_of(s_in_red, s_in_green, s_in_blue);
                    chan_next  = '0;
                    state_next = s_mode ? ST_SETUP : ST_GATHER;
                end
            end
            ST_GATHER: begin
                state_next = ST_IDLE;
            end
            ST_SETUP: begin
                if (cur_hi <= cur_lo) begin
                    res_next[chan_reg] = cur_v;
                    advance = 1'b1;
                end else if (cur_v <= cur_lo) begin
                    res_next[chan_reg] = hcs_pkg::PixMin;
                    advance = 1'b1;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    res_next[chan_reg] = div_quot;
                    advance = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pix_next   = gray_mode_reg ? {NC{res_reg[0]}} : res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance) begin
            if (gray_mode_reg || chan_reg == 2'(NC - 1)) begin
                state_next = ST_FINISH;
            end else begin
                chan_next  = chan_reg + 1'b1;
                state_next = ST_SETUP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chan_reg      <= '0;
            gray_mode_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            gray_mode_reg <= gray_mode_next;
            m_valid_reg   <= m_valid_next;
        end
        first_reg <= first_next;
        px_reg    <= px_next;
        luma_reg  <= luma_next;
        res_reg   <= res_next;
        m_pix_reg <= m_pix_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_pix_reg[0];
    assign m_out_green = m_pix_reg[1];
    assign m_out_blue  = m_pix_reg[2];

`ifndef ASSERT_OFF
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_gray_one_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SETUP && gray_mode_reg) |-> chan_reg == '0)
        else $error("gray apply moved past channel zero");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside the finish state");

    a_start_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");
`endif

endmodule

[hw/rtl/hcs_stats.sv]
// Per-channel running minimum and maximum registers.
// Depends on hcs_pkg for widths and the control struct.
module hcs_stats (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  hcs_pkg::stats_ctl_t                          ctl,
    input  logic [hcs_pkg::NumChan-1:0][hcs_pkg::PixW-1:0] val,
    output logic [hcs_pkg::NumChan-1:0][hcs_pkg::PixW-1:0] min_q,
    output logic [hcs_pkg::NumChan-1:0][hcs_pkg::PixW-1:0] max_q
);

    logic [hcs_pkg::NumChan-1:0][hcs_pkg::PixW-1:0] min_reg, min_next;
    logic [hcs_pkg::NumChan-1:0][hcs_pkg::PixW-1:0] max_reg, max_next;
    logic [hcs_pkg::PixW-1:0] lo_base, hi_base;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        for (int c = 0; c < hcs_pkg::NumChan; c++) begin
            // A first-of-frame fold starts from the cleared values.
            lo_base = ctl.clear ? hcs_pkg::PixMax : min_reg[c];
            hi_base = ctl.clear ? hcs_pkg::PixMin : max_reg[c];
            if (ctl.fold) begin
                min_next[c] = (val[c] < lo_base) ? val[c] : lo_base;
                max_next[c] = (val[c] > hi_base) ? val[c] : hi_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < hcs_pkg::NumChan; c++) begin
                min_reg[c] <= hcs_pkg::PixMax;
                max_reg[c] <= hcs_pkg::PixMin;
            end
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign min_q = min_reg;
    assign max_q = max_reg;

endmodule

[hw/rtl/hcs_div.sv]
// Shared restoring divider: 16-bit dividend by 8-bit divisor, one quotient
// bit per cycle, quotient saturated to 255. Depends on hcs_pkg.
module hcs_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [hcs_pkg::NumW-1:0]   dividend,
    input  logic [hcs_pkg::PixW-1:0]   divisor,
    output hcs_pkg::div_status_t       status,
    output logic [hcs_pkg::PixW-1:0]   quotient
);

    localparam int unsigned CntW = $clog2(hcs_pkg::PixW);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CntW-1:0]           cnt_reg, cnt_next;
    logic [hcs_pkg::PixW-1:0]  rem_reg, rem_next;
    logic [hcs_pkg::PixW-1:0]  low_reg, low_next;
    logic [hcs_pkg::PixW-1:0]  den_reg, den_next;
    logic [hcs_pkg::PixW:0]    trial;
    logic [hcs_pkg::PixW:0]    diff;
    logic                      ge;

    assign trial = {rem_reg, low_reg[hcs_pkg::PixW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        if (start) begin
            den_next = divisor;
            // A high half at or above the divisor means the quotient exceeds 255.
            if (dividend[hcs_pkg::NumW-1:hcs_pkg::PixW] >= divisor) begin
                low_next  = hcs_pkg::PixMax;
                done_next = 1'b1;
            end else begin
                rem_next  = dividend[hcs_pkg::NumW-1:hcs_pkg::PixW];
                low_next  = dividend[hcs_pkg::PixW-1:0];
                cnt_next  = CntW'(hcs_pkg::PixW - 1);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = ge ? diff[hcs_pkg::PixW-1:0] : trial[hcs_pkg::PixW-1:0];
            low_next = {low_reg[hcs_pkg::PixW-2:0], ge};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = low_reg;

endmodule

[dv/hcs_checker.sv]
`timescale 1ns / 100ps
// Checker for the histogram contrast stretch core: tracks min/max and gray mode,
// predicts each stretched pixel and compares it with the result channel.
// Depends on hcs_pkg for the pixel width and the channel count.
module hcs_checker (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_mode,
    input  logic                     s_first_of_frame,
    input  logic [hcs_pkg::PixW-1:0] s_in_red,
    input  logic [hcs_pkg::PixW-1:0] s_in_green,
    input  logic [hcs_pkg::PixW-1:0] s_in_blue,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [hcs_pkg::PixW-1:0] m_out_red,
    input  logic [hcs_pkg::PixW-1:0] m_out_green,
    input  logic [hcs_pkg::PixW-1:0] m_out_blue,
    output int                       mismatch_count,
    output int                       outstanding,
    output int                       pixels_checked
);

    typedef logic [hcs_pkg::PixW-1:0] pix_t;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
    } rgb_t;

    pix_t ch_lo [hcs_pkg::NumChan];
    pix_t ch_hi [hcs_pkg::NumChan];
    logic gray_q;
    rgb_t stretched_q [$];

    function automatic pix_t luma(pix_t r, pix_t g, pix_t b);
        int acc;
        acc = 11 * int'(r) + 16 * int'(g) + 5 * int'(b);
        return pix_t'(acc >> 5);
    endfunction

    // Flat or empty range passes through; below the minimum gives zero; above the
    // maximum the quotient runs past full scale and is clamped.
    function automatic pix_t stretch_val(pix_t lo, pix_t hi, pix_t v);
        int num;
        int den;
        int q;
        if (hi <= lo) return v;
        if (v <= lo) return '0;
        num = 255 * (int'(v) - int'(lo));
        den = int'(hi) - int'(lo);
        q = num / den;
        return (q > 255) ? hcs_pkg::PixMax : pix_t'(q);
    endfunction

    function automatic void fold_stat(int c, pix_t v);
        if (v < ch_lo[c]) ch_lo[c] = v;
        if (v > ch_hi[c]) ch_hi[c] = v;
    endfunction

    always @(posedge aclk) begin
        rgb_t got;
        rgb_t want;
        pix_t px [hcs_pkg::NumChan];
        pix_t y;
        if (!aresetn) begin
            for (int c = 0; c < hcs_pkg::NumChan; c++) begin
                ch_lo[c] = hcs_pkg::PixMax;
                ch_hi[c] = hcs_pkg::PixMin;
            end
            gray_q = 1'b0;
            stretched_q.delete();
        end else begin
            if (cfg_wr_en) gray_q = cfg_wr_data;

            if (m_valid && m_ready) begin
                got = '{red: m_out_red, green: m_out_green, blue: m_out_blue};
                if (stretched_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result r=%0d g=%0d b=%0d with no request pending",
                                 $realtime, got.red, got.green, got.blue);
                    mismatch_count++;
                end else begin
                    want = stretched_q.pop_front();
                    pixels_checked++;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        if (mismatch_count < 10)
                            $display("%0t: mismatch, expected r=%0d g=%0d b=%0d,%s",
                                     $realtime, want.red, want.green, want.blue,
                                     $sformatf(" got r=%0d g=%0d b=%0d",
                                               got.red, got.green, got.blue));
                        mismatch_count++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                px[0] = s_in_red;
                px[1] = s_in_green;
                px[2] = s_in_blue;
                y = luma(px[0], px[1], px[2]);
                if (!s_mode) begin
                    if (s_first_of_frame) begin
                        for (int c = 0; c < hcs_pkg::NumChan; c++) begin
                            ch_lo[c] = hcs_pkg::PixMax;
                            ch_hi[c] = hcs_pkg::PixMin;
                        end
                    end
                    for (int c = 0; c < hcs_pkg::NumChan; c++)
                        fold_stat(c, gray_q ? y : px[c]);
                end else if (gray_q) begin
                    // Gray mode stretches with the statistics of the first entry only.
                    want.red   = stretch_val(ch_lo[0], ch_hi[0], y);
                    want.green = want.red;
                    want.blue  = want.red;
                    stretched_q.push_back(want);
                end else begin
                    want.red   = stretch_val(ch_lo[0], ch_hi[0], px[0]);
                    want.green = stretch_val(ch_lo[1], ch_hi[1], px[1]);
                    want.blue  = stretch_val(ch_lo[2], ch_hi[2], px[2]);
                    stretched_q.push_back(want);
                end
            end
        end
        outstanding = stretched_q.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for histogram_contrast_stretch_core: drives gather/apply requests and the
// gray-mode register, throttles the result channel; depends on hcs_pkg and hcs_checker.
module tb_top;

    typedef logic [hcs_pkg::PixW-1:0] pix_t;

    localparam int DrainCycles = 40;
    localparam int HoldCycles  = 300;
    localparam int PhaseItems  = 170;
    localparam int TimeoutNs   = 4_000_000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_valid = 1'b0;
    logic s_mode = 1'b0;
    logic s_first_of_frame = 1'b0;
    pix_t s_in_red = '0;
    pix_t s_in_green = '0;
    pix_t s_in_blue = '0;
    logic m_ready = 1'b0;
    logic s_ready;
    logic m_valid;
    pix_t m_out_red;
    pix_t m_out_green;
    pix_t m_out_blue;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_results = 1'b0;
    logic gray_now = 1'b0;
    int   gathers_sent = 0;
    int   applies_sent = 0;
    int   phase_items = 0;
    int   cfg_writes = 0;
    int   mismatch_count;
    int   outstanding;
    int   pixels_checked;

    histogram_contrast_stretch_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_first_of_frame (s_first_of_frame),
        .s_in_red         (s_in_red),
        .s_in_green       (s_in_green),
        .s_in_blue        (s_in_blue),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_red        (m_out_red),
        .m_out_green      (m_out_green),
        .m_out_blue       (m_out_blue)
    );

    hcs_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_first_of_frame (s_first_of_frame),
        .s_in_red         (s_in_red),
        .s_in_green       (s_in_green),
        .s_in_blue        (s_in_blue),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_red        (m_out_red),
        .m_out_green      (m_out_green),
        .m_out_blue       (m_out_blue),
        .mismatch_count   (mismatch_count),
        .outstanding      (outstanding),
        .pixels_checked   (pixels_checked)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        if (hold_results) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send(input logic mode, input logic first,
                        input pix_t r, input pix_t g, input pix_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_mode           <= mode;
        s_first_of_frame <= first;
        s_in_red         <= r;
        s_in_green       <= g;
        s_in_blue        <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (mode) applies_sent++;
        else gathers_sent++;
        phase_items++;
    endtask

    // A gather leaves nothing to wait for, so some cycles pass after the last result.
    task automatic settle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    task automatic set_gray(input logic on);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        gray_now = on;
        cfg_writes++;
    endtask

    function automatic pix_t pick_apply(pix_t lo, pix_t hi);
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return pix_t'($urandom_range(hi, lo));
        if (sel < 85) return pix_t'($urandom_range(255));
        return sel[0] ? hcs_pkg::PixMax : hcs_pkg::PixMin;
    endfunction

    task automatic directed();
        // Apply straight after reset sees an empty range and passes through; the
        // frame flag on an apply is ignored.
        send(1'b1, 1'b0, 8'd0, 8'd128, 8'd255);
        send(1'b1, 1'b1, 8'd255, 8'd0, 8'd1);
        // Zero counts in the statistics; full range 0..255.
        send(1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
        send(1'b0, 1'b0, 8'd255, 8'd255, 8'd255);
        send(1'b1, 1'b0, 8'd0, 8'd255, 8'd127);
        // Green is flat; the rest cover below-min, at the ends, mid and above-max.
        send(1'b0, 1'b1, 8'd50, 8'd100, 8'd10);
        send(1'b0, 1'b0, 8'd150, 8'd100, 8'd200);
        send(1'b1, 1'b0, 8'd40, 8'd100, 8'd205);
        send(1'b1, 1'b0, 8'd50, 8'd99, 8'd10);
        send(1'b1, 1'b1, 8'd150, 8'd101, 8'd200);
        send(1'b1, 1'b0, 8'd100, 8'd0, 8'd105);
        set_gray(1'b1);
        send(1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
        send(1'b0, 1'b0, 8'd255, 8'd255, 8'd255);
        send(1'b1, 1'b0, 8'd128, 8'd64, 8'd200);
        send(1'b1, 1'b0, 8'd0, 8'd0, 8'd0);
        send(1'b1, 1'b0, 8'd255, 8'd255, 8'd255);
        send(1'b0, 1'b1, 8'd100, 8'd100, 8'd100);
        send(1'b0, 1'b0, 8'd200, 8'd50, 8'd10);
        send(1'b1, 1'b0, 8'd10, 8'd10, 8'd10);
        send(1'b1, 1'b0, 8'd255, 8'd255, 8'd255);
        // Statistics gathered as luma, applied per color channel.
        set_gray(1'b0);
        send(1'b1, 1'b0, 8'd100, 8'd100, 8'd100);
        send(1'b1, 1'b0, 8'd90, 8'd20, 8'd250);
        set_gray(1'b1);
        send(1'b0, 1'b1, 8'd77, 8'd77, 8'd77);
        send(1'b1, 1'b0, 8'd30, 8'd200, 8'd90);
        set_gray(1'b0);
    endtask

    // The receiver stops for a long stretch while applies keep coming, so the
    // output register fills and the core stops taking requests.
    task automatic pressure_burst();
        fork
            begin
                @(posedge aclk);
                hold_results = 1'b1;
                repeat (HoldCycles) @(posedge aclk);
                hold_results = 1'b0;
            end
            for (int i = 0; i < 16; i++)
                send(1'b1, 1'($urandom_range(1)), pix_t'($urandom_range(255)),
                     pix_t'($urandom_range(255)), pix_t'($urandom_range(255)));
        join
    endtask

    task automatic random_frame();
        int   n_gather;
        int   n_apply;
        pix_t lo [3];
        pix_t hi [3];
        pix_t px [3];
        pix_t a;
        pix_t b;
        logic first;
        if ($urandom_range(99) < 20) set_gray(~gray_now);
        n_gather = $urandom_range(10, 1);
        n_apply  = $urandom_range(12, 1);
        for (int c = 0; c < 3; c++) begin
            a = pix_t'($urandom_range(255));
            b = pix_t'($urandom_range(255));
            lo[c] = (a < b) ? a : b;
            hi[c] = (a < b) ? b : a;
            if ($urandom_range(99) < 10) hi[c] = lo[c];
        end
        for (int i = 0; i < n_gather; i++) begin
            for (int c = 0; c < 3; c++)
                px[c] = (i == 0) ? lo[c] : (i == 1) ? hi[c] :
                        pix_t'($urandom_range(hi[c], lo[c]));
            // Now and then a frame starts without the flag and keeps the old statistics.
            first = (i == 0) ? ($urandom_range(99) >= 5) : ($urandom_range(99) < 3);
            send(1'b0, first, px[0], px[1], px[2]);
        end
        for (int i = 0; i < n_apply; i++) begin
            if ($urandom_range(99) < 10) begin
                send(1'($urandom_range(1)), 1'($urandom_range(1)),
                     pix_t'($urandom_range(255)), pix_t'($urandom_range(255)),
                     pix_t'($urandom_range(255)));
            end else begin
                for (int c = 0; c < 3; c++) px[c] = pick_apply(lo[c], hi[c]);
                send(1'b1, 1'($urandom_range(1)), px[0], px[1], px[2]);
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        directed();
        pressure_burst();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 59;
                end
                default: begin
                    send_idle_pct = 12;
                    recv_stall_pct = 12;
                end
            endcase
            phase_items = 0;
            while (phase_items < PhaseItems) random_frame();
        end
        settle();
        $display("Run covered %0d gather and %0d apply requests with %0d gray-mode writes,",
                 gathers_sent, applies_sent, cfg_writes);
        $display("under four throttling phases and one long result stall; %0d pixels checked.",
                 pixels_checked);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(TimeoutNs);
        $display("Timed out with %0d results still outstanding.", outstanding);
        $display("TEST FAILED");
        $finish;
    end

endmodule
